// File: rtl/ctbst_pkg.sv
// Package for the CT break supervision timer.
// Holds sizes, field offsets, codes and the per-channel entry layout.
// No dependencies.
package ctbst_pkg;

    localparam int NUM_TIES   = 4;
    localparam int NUM_PHASES = 3;
    localparam int MAG_BITS   = 24;
    localparam int TIME_BITS  = 32;

    localparam int NUM_CH   = NUM_TIES * NUM_PHASES;
    localparam int CH_BITS  = $clog2(NUM_CH);
    localparam int TIE_BITS = 2;
    localparam int PH_BITS  = 2;
    localparam int EV_BITS  = 3;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_THR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WARN_THR  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY     = 2'd2;

    localparam logic [MAG_BITS-1:0]  THR_RST   = '1;
    localparam logic [TIME_BITS-1:0] DELAY_RST = TIME_BITS'(300);

    // input tdata layout
    localparam int OFS_OV    = 0;
    localparam int OFS_A     = OFS_OV + MAG_BITS;
    localparam int OFS_B     = OFS_A + MAG_BITS;
    localparam int OFS_TIE   = OFS_B + MAG_BITS;
    localparam int OFS_PH    = OFS_TIE + TIE_BITS;
    localparam int OFS_NOW   = OFS_PH + PH_BITS;
    localparam int S_FIELD_BITS = OFS_NOW + TIME_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int M_FIELD_BITS = 2 + EV_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [EV_BITS-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_BITS-1:0] EV_BLK_OV  = 3'd1;
    localparam logic [EV_BITS-1:0] EV_BLK_SEC = 3'd2;
    localparam logic [EV_BITS-1:0] EV_WRN_OV  = 3'd3;
    localparam logic [EV_BITS-1:0] EV_WRN_SEC = 3'd4;

    typedef enum logic [2:0] {
        RULE_BLK_OV,
        RULE_BLK_SEC,
        RULE_WRN_OV,
        RULE_WRN_SEC,
        RULE_CLR
    } rule_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] blk_ov;
        logic [TIME_BITS-1:0] blk_sec;
        logic [TIME_BITS-1:0] wrn_ov;
        logic [TIME_BITS-1:0] wrn_sec;
        logic                 blk_flag;
        logic                 wrn_flag;
    } chan_entry_t;

endpackage

// File: rtl/ctbst_chan_update.sv
// Rule engine for one channel entry: steps the selected timer and sets its flag; warn rules also zero the block
// timers and the clear rule zeroes all timers. Depends on ctbst_pkg.
module ctbst_chan_update
    import ctbst_pkg::*;
(
    input  rule_t                rule,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [TIME_BITS-1:0] delay,
    input  chan_entry_t          cur,
    output chan_entry_t          nxt,
    output logic [EV_BITS-1:0]   event_code
);

    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] new_start;
    logic                 idle;
    logic                 expired;

    always_comb begin
        case (rule)
            RULE_BLK_OV:  start = cur.blk_ov;
            RULE_BLK_SEC: start = cur.blk_sec;
            RULE_WRN_OV:  start = cur.wrn_ov;
            RULE_WRN_SEC: start = cur.wrn_sec;
            default:      start = '0;
        endcase
    end

    assign idle      = (start == '0);
    assign elapsed   = now_time - start;
    assign expired   = !idle && (elapsed > delay);
    assign new_start = idle ? now_time : (expired ? '0 : start);

    always_comb begin
        nxt        = cur;
        event_code = EV_NONE;
        case (rule)
            RULE_BLK_OV: begin
                nxt.blk_ov = new_start;
                if (expired) begin
                    nxt.blk_flag = 1'b1;
                    event_code   = EV_BLK_OV;
                end
            end
            RULE_BLK_SEC: begin
                nxt.blk_sec = new_start;
                if (expired) begin
                    nxt.blk_flag = 1'b1;
                    event_code   = EV_BLK_SEC;
                end
            end
            RULE_WRN_OV: begin
                nxt.blk_ov  = '0;
                nxt.blk_sec = '0;
                nxt.wrn_ov  = new_start;
                if (expired) begin
                    nxt.wrn_flag = 1'b1;
                    event_code   = EV_WRN_OV;
                end
            end
            RULE_WRN_SEC: begin
                nxt.blk_ov  = '0;
                nxt.blk_sec = '0;
                nxt.wrn_sec = new_start;
                if (expired) begin
                    nxt.wrn_flag = 1'b1;
                    event_code   = EV_WRN_SEC;
                end
            end
            default: begin
                nxt.blk_ov  = '0;
                nxt.blk_sec = '0;
                nxt.wrn_ov  = '0;
                nxt.wrn_sec = '0;
            end
        endcase
    end

endmodule

// File: rtl/ct_break_supervision_timer.sv
// Path: an accepted item is held in stage 1 while the table is read, then updated into the output register (m_tvalid).
// Throughput: one item per cycle while m_tready does not hold the output; the channel table is read into a
// register on accept and written back as stage 1 moves on, with a one-entry forward for back-to-back same channel.
// Reset: synchronous, active low; clears config to defaults, entry valid bits,
// pipeline and output valids. No clearing pass: invalid entries read as idle.
// Depends on ctbst_pkg and ctbst_chan_update.
module ct_break_supervision_timer
    import ctbst_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // cfg channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // overall_diff_mag, section_a_diff_mag, section_b_diff_mag, tie_index,
    // phase_index, now_time, zero pad
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    // result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // block_flag, warn_flag, event_code, zero pad
    output logic [M_TDATA_BITS-1:0]  m_tdata
);

    logic [MAG_BITS-1:0]  blk_thr_reg;
    logic [MAG_BITS-1:0]  wrn_thr_reg;
    logic [TIME_BITS-1:0] delay_reg;

    chan_entry_t          mem [NUM_CH];
    logic [NUM_CH-1:0]    ent_valid_reg;
    chan_entry_t          rd_data_reg;
    logic                 rd_valid_reg;

    logic                 s1_valid_reg;
    logic                 s1_inrange_reg;
    logic [CH_BITS-1:0]   s1_ch_reg;
    rule_t                s1_rule_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    chan_entry_t          fwd_data_reg;
    logic [CH_BITS-1:0]   fwd_ch_reg;
    logic                 fwd_valid_reg;

    logic                 m_valid_reg;
    logic [M_FIELD_BITS-1:0] m_data_reg;

    logic [MAG_BITS-1:0]  in_ov, in_a, in_b;
    logic [TIE_BITS-1:0]  in_tie;
    logic [PH_BITS-1:0]   in_ph;
    logic [TIME_BITS-1:0] in_now;
    logic                 in_range;
    logic [CH_BITS-1:0]   in_ch;
    rule_t                in_rule;

    logic                 out_free;
    logic                 s_accept;
    logic                 s1_fire;
    logic                 mem_we;
    chan_entry_t          cur_entry;
    chan_entry_t          nxt_entry;
    logic [EV_BITS-1:0]   ev_code;
    logic [M_FIELD_BITS-1:0] result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_thr_reg <= THR_RST;
            wrn_thr_reg <= THR_RST;
            delay_reg   <= DELAY_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLOCK_THR: blk_thr_reg <= cfg_data[MAG_BITS-1:0];
                CFG_WARN_THR:  wrn_thr_reg <= cfg_data[MAG_BITS-1:0];
                CFG_DELAY:     delay_reg   <= cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input decode and rule selection
    assign in_ov  = s_tdata[OFS_OV +: MAG_BITS];
    assign in_a   = s_tdata[OFS_A +: MAG_BITS];
    assign in_b   = s_tdata[OFS_B +: MAG_BITS];
    assign in_tie = s_tdata[OFS_TIE +: TIE_BITS];
    assign in_ph  = s_tdata[OFS_PH +: PH_BITS];
    assign in_now = s_tdata[OFS_NOW +: TIME_BITS];

    assign in_range = (int'(in_tie) < NUM_TIES) && (int'(in_ph) < NUM_PHASES);
    assign in_ch    = in_range ? CH_BITS'(CH_BITS'(in_tie) * CH_BITS'(NUM_PHASES)
                                          + CH_BITS'(in_ph))
                               : '0;

    always_comb begin
        if (in_ov > blk_thr_reg) begin
            in_rule = RULE_BLK_OV;
        end else if (in_a > blk_thr_reg && in_b > blk_thr_reg) begin
            in_rule = RULE_BLK_SEC;
        end else if (in_ov > wrn_thr_reg) begin
            in_rule = RULE_WRN_OV;
        end else if (in_a > wrn_thr_reg && in_b > wrn_thr_reg) begin
            in_rule = RULE_WRN_SEC;
        end else begin
            in_rule = RULE_CLR;
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign mem_we   = s1_fire && s1_inrange_reg;

    // channel table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s1_ch_reg] <= nxt_entry;
        end
        if (s_tready) begin
            rd_data_reg <= mem[in_ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                ent_valid_reg[s1_ch_reg] <= 1'b1;
                fwd_valid_reg            <= 1'b1;
            end
            if (s_tready) begin
                rd_valid_reg <= ent_valid_reg[in_ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fwd_data_reg <= nxt_entry;
            fwd_ch_reg   <= s1_ch_reg;
        end
    end

    // stage 1 pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_inrange_reg <= in_range;
            s1_ch_reg      <= in_ch;
            s1_rule_reg    <= in_rule;
            s1_now_reg     <= in_now;
        end
    end

    // last write wins over the registered read
    always_comb begin
        if (fwd_valid_reg && fwd_ch_reg == s1_ch_reg) begin
            cur_entry = fwd_data_reg;
        end else if (rd_valid_reg) begin
            cur_entry = rd_data_reg;
        end else begin
            cur_entry = '0;
        end
    end

    ctbst_chan_update u_update (
        .rule       (s1_rule_reg),
        .now_time   (s1_now_reg),
        .delay      (delay_reg),
        .cur        (cur_entry),
        .nxt        (nxt_entry),
        .event_code (ev_code)
    );

    assign result = s1_inrange_reg ? {ev_code, nxt_entry.wrn_flag, nxt_entry.blk_flag}
                                   : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - M_FIELD_BITS){1'b0}}, m_data_reg};

    // checks
    a_blk_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:2] == EV_BLK_OV || m_tdata[4:2] == EV_BLK_SEC)
        |-> m_tdata[0])
        else $error("block event without block flag");

    a_wrn_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:2] == EV_WRN_OV || m_tdata[4:2] == EV_WRN_SEC)
        |-> m_tdata[1])
        else $error("warn event without warn flag");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:2] <= EV_WRN_SEC)
        else $error("event code out of range");

    a_write_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_valid_reg && out_free)
        else $error("table write without an item in stage 1");

    a_fill_entry_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> ent_valid_reg[$past(s1_ch_reg)] && fwd_valid_reg)
        else $error("written entry not marked valid");

endmodule
